[sv/stw_pkg.sv]
package stw_pkg;

  localparam int unsigned WHEEL_SLOTS = 256;
  localparam int unsigned SLOT_W      = $clog2(WHEEL_SLOTS);
  localparam int unsigned DELAY_W     = 8;
  localparam int unsigned TAG_W       = 32;
  localparam int unsigned ARG_W       = 32;
  localparam int unsigned COUNT_W     = 64;
  localparam int unsigned ENTRY_W     = TAG_W + ARG_W;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    CMD_TICK     = 1'b0,
    CMD_SCHEDULE = 1'b1
  } cmd_t;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic               command;
    logic [DELAY_W-1:0] delay;
    logic [TAG_W-1:0]   event_tag;
    logic [ARG_W-1:0]   event_arg;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic               fired;
    logic [TAG_W-1:0]   fired_tag;
    logic [ARG_W-1:0]   fired_arg;
    logic [COUNT_W-1:0] tick_count;
  } result_t;

  // Classified operation handed from the front to the back
  typedef struct packed {
    logic             schedule;
    slot_t            slot;
    logic [TAG_W-1:0] tag;
    logic [ARG_W-1:0] arg;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[sv/stw_ram.sv]
module stw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/stw_front.sv]
module stw_front import stw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  item_t     item,
  input  q_status_t q_stat,
  output logic      push,
  output op_t       op
);

  slot_t pos;
  slot_t pos_next;
  slot_t delay_slot;
  logic  is_sched;

  // Reduce the delay modulo the wheel size by restoring subtraction
  function automatic slot_t reduce_delay(input logic [DELAY_W-1:0] d);
    logic [DELAY_W-1:0] r;
    r = d;
    for (int k = DELAY_W; k >= 0; k--) begin
      if (32'(r) >= (WHEEL_SLOTS << k)) begin
        r = r - DELAY_W'(WHEEL_SLOTS << k);
      end
    end
    return slot_t'(r);
  endfunction

  function automatic slot_t add_slot(input slot_t a, input slot_t b);
    logic [SLOT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (32'(sum) >= WHEEL_SLOTS) begin
      sum = sum - (SLOT_W + 1)'(WHEEL_SLOTS);
    end
    return sum[SLOT_W-1:0];
  endfunction

  assign item_ready = !q_stat.full;
  assign push       = item_valid && item_ready;
  assign is_sched   = (item.command == CMD_SCHEDULE);

  always_comb begin
    delay_slot  = reduce_delay(item.delay);
    op.schedule = is_sched;
    op.slot     = is_sched ? add_slot(pos, delay_slot) : pos;
    op.tag      = item.event_tag;
    op.arg      = item.event_arg;
  end

  // Track the current slot; every tick goes through here in order
  always_comb begin
    pos_next = pos;
    if (push && !is_sched) begin
      pos_next = (pos == SLOT_W'(WHEEL_SLOTS - 1)) ? '0 : pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

endmodule

[sv/stw_queue.sv]
module stw_queue import stw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  op_t       push_op,
  input  logic      pop,
  output op_t       head,
  output q_status_t q_stat
);

  op_t               store [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] cnt;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head         = store[rptr];
  assign q_stat.full  = (cnt == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      store[wptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= bump(wptr);
      end
      if (pop) begin
        rptr <= bump(rptr);
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

[sv/stw_back.sv]
module stw_back import stw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  op_t       head,
  input  q_status_t q_stat,
  output logic      pop,
  output logic      result_valid,
  input  logic      result_ready,
  output result_t   result
);

  logic [WHEEL_SLOTS-1:0] occ;
  logic [WHEEL_SLOTS-1:0] occ_next;
  logic [COUNT_W-1:0]     count;
  logic [COUNT_W-1:0]     count_next;

  logic                   s2_valid;
  logic                   s2_acc;
  logic                   s2_fire;
  logic [COUNT_W-1:0]     s2_count;

  logic                   out_free;
  logic                   s2_adv;
  logic                   hit;
  logic                   sched_take;
  logic                   tick_fire;
  logic [ENTRY_W-1:0]     rdata;
  result_t                s2_result;

  assign out_free   = !result_valid || result_ready;
  assign s2_adv     = s2_valid && out_free;
  assign pop        = !q_stat.empty && (!s2_valid || out_free);
  assign hit        = occ[head.slot];
  assign sched_take = pop && head.schedule && !hit;
  assign tick_fire  = pop && !head.schedule && hit;

  stw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WHEEL_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (sched_take),
    .waddr (head.slot),
    .wdata ({head.tag, head.arg}),
    .re    (tick_fire),
    .raddr (head.slot),
    .rdata (rdata)
  );

  // A slot counts as occupied only with a nonzero tag; a tick always empties it
  always_comb begin
    occ_next   = occ;
    count_next = count;
    if (pop) begin
      if (head.schedule) begin
        if (!hit && (head.tag != '0)) begin
          occ_next[head.slot] = 1'b1;
        end
      end else begin
        occ_next[head.slot] = 1'b0;
        count_next          = count + 1'b1;
      end
    end
  end

  always_comb begin
    s2_result.accepted   = s2_acc;
    s2_result.fired      = s2_fire;
    s2_result.fired_tag  = s2_fire ? rdata[ENTRY_W-1:ARG_W] : '0;
    s2_result.fired_arg  = s2_fire ? rdata[ARG_W-1:0] : '0;
    s2_result.tick_count = s2_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ          <= '0;
      count        <= '0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      occ   <= occ_next;
      count <= count_next;
      if (pop) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s2_adv) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_acc   <= sched_take;
      s2_fire  <= tick_fire;
      s2_count <= count_next;
    end
    if (s2_adv) begin
      result <= s2_result;
    end
  end

endmodule

[sv/single_level_timer_wheel_core.sv]
// Single-level timing wheel: 256 slots of (tag, argument) and a 64-bit tick count.
// Input channel item_valid / item_ready / item carries one command per transfer:
//   a tick fires the event in the current slot (if any), empties it and advances
//   the count; a schedule places an event delay slots ahead if that slot is free.
// Output channel result_valid / result_ready / result returns one result per
// input transfer, in order, with the tick count after that step.
// Path: the transfer edge writes the queue, then the back reads the slot with a
// registered RAM read, then the output register presents the result.
// Throughput: one item per cycle while the receiver takes results; the back retires
// at most one queued op per cycle, which sets that figure. A two-entry queue
// decouples front and back.
// Reset (rst, synchronous): clear the occupancy bits of all slots at once, the
// count and all valid flags. Slot RAM contents are not cleared; an unoccupied slot
// is never read.
// When the receiver stalls, hold the result; the back then stops draining the
// queue, and item_ready drops once the queue fills.
module single_level_timer_wheel_core import stw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  q_status_t q_stat;
  logic      push;
  logic      pop;
  op_t       push_op;
  op_t       head;

  // Classify commands and resolve the target slot
  stw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_stat     (q_stat),
    .push       (push),
    .op         (push_op)
  );

  // Hold classified ops between front and back
  stw_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  // Access the wheel, advance the count, and register results
  stw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_stat       (q_stat),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Never push into a full queue
  assert property (@(posedge clk) disable iff (rst) q_stat.full |-> !push)
    else $error("queue overflow");

  // Never pop from an empty queue
  assert property (@(posedge clk) disable iff (rst) q_stat.empty |-> !pop)
    else $error("queue underflow");

  // A result is either a schedule outcome or a tick outcome, never both
  assert property (@(posedge clk) disable iff (rst)
      result_valid |-> !(result.accepted && result.fired))
    else $error("accepted and fired both set");

  // A fired event always carries a nonzero tag; a quiet result carries zeros
  assert property (@(posedge clk) disable iff (rst)
      result_valid |-> (result.fired ? (result.fired_tag != '0)
                                     : (result.fired_tag == '0 && result.fired_arg == '0)))
    else $error("fired payload inconsistent");

endmodule
